### src/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

	localparam int MAX_PAGES  = 1024;
	localparam int PAGE_W     = $clog2(MAX_PAGES);
	localparam int CNT_W      = PAGE_W + 1;
	localparam int NODE_W     = PAGE_W + 1;
	localparam int NODE_DEPTH = 2 * MAX_PAGES;
	localparam int LG_W       = $clog2(CNT_W + 1);
	localparam int FLAG_W     = 4;

	typedef logic [FLAG_W-1:0] flags_t;

	localparam flags_t FL_LEFT  = 4'd1;
	localparam flags_t FL_RIGHT = 4'd2;
	localparam flags_t FL_FULL  = 4'd4;
	localparam flags_t FL_OUT   = 4'd8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// smallest k with 2**k >= v (0 for v of 0 or 1)
	function automatic logic [LG_W-1:0] clog2_cnt(input logic [CNT_W-1:0] v);
		logic [LG_W-1:0] r;
		r = LG_W'(CNT_W);
		for (int k = CNT_W - 1; k >= 0; k--) begin
			if (((CNT_W+1)'(1) << k) >= {1'b0, v}) begin
				r = LG_W'(k);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### src/bpa_ram.sv
`default_nettype none
module bpa_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

### src/buddy_page_allocator.sv
`default_nettype none
// Buddy page allocator. Pulse start while busy is low; the item is taken at
// that edge and a single result appears later on ok/page_index for exactly one
// cycle with done high. The receiver cannot stall, so results must be captured
// when done is seen. An allocate walks the node tree: it steps down one node at
// a time, moves from each rejected node to the one next to it and climbs a level
// where none is left, then marks the block and, for each ancestor, reads the
// sibling and the parent and writes the parent. A free climbs from the leaf
// level by level, then clears the full marks up to the root and then the side
// marks until a parent stays in use. A zero or oversize allocate and a free
// beyond the tree answer in the cycle after start. The single-port flag memory
// paces these steps. After reset and after every pool_pages write the tree's
// 2*R-1 nodes are rebuilt, one node per cycle, with R the pool size rounded up
// to a power of two (R is 1024 after reset); busy stays high meanwhile.
// A pool_pages write forgets all allocations.
module buddy_page_allocator
	import bpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              operation,
	input  wire logic [CNT_W-1:0]  size_pages,
	input  wire logic [PAGE_W-1:0] first_page,
	output logic                   done,
	output logic                   ok,
	output logic      [PAGE_W-1:0] page_index,
	input  wire logic              pool_pages_we,
	input  wire logic [CNT_W-1:0]  pool_pages
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BUILD = 4'd1;
	localparam logic [3:0] ST_S_EV  = 4'd2;
	localparam logic [3:0] ST_S_ADV = 4'd3;
	localparam logic [3:0] ST_MK    = 4'd4;
	localparam logic [3:0] ST_C0    = 4'd5;
	localparam logic [3:0] ST_C1    = 4'd6;
	localparam logic [3:0] ST_C2    = 4'd7;
	localparam logic [3:0] ST_F1    = 4'd8;
	localparam logic [3:0] ST_FC0   = 4'd9;
	localparam logic [3:0] ST_FC1   = 4'd10;
	localparam logic [3:0] ST_FS0   = 4'd11;
	localparam logic [3:0] ST_FS1   = 4'd12;

	logic [3:0]        state_q, state_d;
	logic [NODE_W-1:0] a_q, a_d, p_q, p_d;
	logic [LG_W-1:0]   d_q, d_d, td_q, td_d, lg_q, lg_d;
	flags_t            bf_q, bf_d, sib_q, sib_d;
	logic              prev_odd_q, prev_odd_d;
	logic [CNT_W-1:0]  start_q, start_d, size_q, size_d, pool_q, pool_d;
	logic              done_q, done_d, ok_q, ok_d;
	logic [PAGE_W-1:0] page_q, page_d;

	logic              ram_we;
	logic [NODE_W-1:0] ram_addr;
	flags_t            ram_wdata, ram_rdata;

	logic [CNT_W-1:0]  root;
	logic [CNT_W-1:0]  clamp;
	logic [CNT_W:0]    end_pg, lo_end;
	logic              out_b, lo_b, big_b;
	flags_t            nv;
	logic [NODE_W-1:0] up;

	assign root  = CNT_W'(1) << lg_q;
	assign clamp = (pool_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pool_pages;
	assign up    = a_q >> 1;

	// build flags for the node at (start_q, size_q)
	assign end_pg = {1'b0, start_q} + {1'b0, size_q};
	assign lo_end = {1'b0, start_q} + {2'b0, size_q[CNT_W-1:1]};
	assign out_b  = end_pg > {1'b0, pool_q};
	assign lo_b   = lo_end > {1'b0, pool_q};
	assign big_b  = size_q > CNT_W'(1);

	bpa_ram #(.WIDTH(FLAG_W), .DEPTH(NODE_DEPTH)) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		a_d        = a_q;
		p_d        = p_q;
		d_d        = d_q;
		td_d       = td_q;
		lg_d       = lg_q;
		bf_d       = bf_q;
		sib_d      = sib_q;
		prev_odd_d = prev_odd_q;
		start_d    = start_q;
		size_d     = size_q;
		pool_d     = pool_q;
		done_d     = 1'b0;
		ok_d       = ok_q;
		page_d     = page_q;
		ram_we     = 1'b0;
		ram_addr   = a_q;
		ram_wdata  = '0;
		nv         = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					page_d = '0;
					if (operation == OP_ALLOC) begin
						if (size_pages == '0 || size_pages > root) begin
							done_d = 1'b1;
							ok_d   = 1'b0;
						end else begin
							td_d     = lg_q - clog2_cnt(size_pages);
							a_d      = NODE_W'(1);
							d_d      = '0;
							ram_addr = NODE_W'(1);
							state_d  = ST_S_EV;
						end
					end else begin
						if ({1'b0, first_page} >= root) begin
							done_d = 1'b1;
							ok_d   = 1'b0;
						end else begin
							a_d        = root + {1'b0, first_page};
							ram_addr   = a_d;
							prev_odd_d = 1'b0;
							state_d    = ST_F1;
						end
					end
				end
			end
			ST_BUILD: begin
				ram_we    = 1'b1;
				ram_addr  = a_q;
				ram_wdata = out_b ? (FL_OUT | (big_b ? FL_RIGHT : '0)
					| ((big_b && lo_b) ? FL_LEFT : '0)) : '0;
				a_d = a_q + NODE_W'(1);
				if (end_pg[CNT_W-1:0] == root) begin
					start_d = '0;
					size_d  = size_q >> 1;
					if (!big_b) begin
						state_d = ST_IDLE;
					end
				end else begin
					start_d = end_pg[CNT_W-1:0];
				end
			end
			ST_S_EV: begin
				if (d_q == td_q) begin
					state_d = (ram_rdata == '0) ? ST_MK : ST_S_ADV;
				end else if ((ram_rdata & FL_FULL) != '0) begin
					state_d = ST_S_ADV;
				end else begin
					a_d      = {a_q[NODE_W-2:0], 1'b0};
					d_d      = d_q + LG_W'(1);
					ram_addr = a_d;
				end
			end
			ST_S_ADV: begin
				if (a_q == NODE_W'(1)) begin
					done_d  = 1'b1;
					ok_d    = 1'b0;
					state_d = ST_IDLE;
				end else if (a_q[0]) begin
					a_d = up;
					d_d = d_q - LG_W'(1);
				end else begin
					a_d      = a_q + NODE_W'(1);
					ram_addr = a_d;
					state_d  = ST_S_EV;
				end
			end
			ST_MK: begin
				ram_we    = 1'b1;
				ram_addr  = a_q;
				ram_wdata = FL_FULL;
				bf_d      = FL_FULL;
				page_d    = PAGE_W'((a_q << (lg_q - d_q)) - root);
				if (a_q == NODE_W'(1)) begin
					done_d  = 1'b1;
					ok_d    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_C0;
				end
			end
			ST_C0: begin
				ram_addr = a_q ^ NODE_W'(1);
				state_d  = ST_C1;
			end
			ST_C1: begin
				sib_d    = ram_rdata;
				ram_addr = up;
				state_d  = ST_C2;
			end
			ST_C2: begin
				nv = ram_rdata | (a_q[0] ? FL_RIGHT : FL_LEFT)
					| ((((bf_q & sib_q) & FL_FULL) != '0) ? FL_FULL : '0);
				ram_we    = 1'b1;
				ram_addr  = up;
				ram_wdata = nv;
				bf_d      = nv;
				a_d       = up;
				if (up == NODE_W'(1)) begin
					done_d  = 1'b1;
					ok_d    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_C0;
				end
			end
			ST_F1: begin
				if (ram_rdata == '0 && !prev_odd_q) begin
					prev_odd_d = a_q[0];
					a_d        = up;
					ram_addr   = up;
					if (up == '0) begin
						done_d  = 1'b1;
						ok_d    = 1'b0;
						state_d = ST_IDLE;
					end
				end else if (ram_rdata == FL_FULL) begin
					p_d     = a_q;
					state_d = ST_FC0;
				end else begin
					done_d  = 1'b1;
					ok_d    = 1'b0;
					state_d = ST_IDLE;
				end
			end
			ST_FC0: begin
				ram_addr = p_q;
				state_d  = ST_FC1;
			end
			ST_FC1: begin
				ram_we    = 1'b1;
				ram_addr  = p_q;
				ram_wdata = ram_rdata & ~FL_FULL;
				if (p_q == NODE_W'(1)) begin
					state_d = ST_FS0;
				end else begin
					p_d     = p_q >> 1;
					state_d = ST_FC0;
				end
			end
			ST_FS0: begin
				if (a_q <= NODE_W'(1)) begin
					done_d  = 1'b1;
					ok_d    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					ram_addr = up;
					state_d  = ST_FS1;
				end
			end
			ST_FS1: begin
				nv        = ram_rdata & ~(a_q[0] ? FL_RIGHT : FL_LEFT);
				ram_we    = 1'b1;
				ram_addr  = up;
				ram_wdata = nv;
				if (nv != '0) begin
					done_d  = 1'b1;
					ok_d    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					a_d     = up;
					state_d = ST_FS0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// a pool write restarts the rebuild sweep
		if (pool_pages_we) begin
			pool_d  = clamp;
			lg_d    = clog2_cnt(clamp);
			a_d     = NODE_W'(1);
			start_d = '0;
			size_d  = CNT_W'(1) << lg_d;
			state_d = ST_BUILD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BUILD;
			pool_q  <= CNT_W'(MAX_PAGES);
			lg_q    <= LG_W'(PAGE_W);
			a_q     <= NODE_W'(1);
			start_q <= '0;
			size_q  <= CNT_W'(MAX_PAGES);
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			page_q  <= '0;
		end else begin
			state_q <= state_d;
			pool_q  <= pool_d;
			lg_q    <= lg_d;
			a_q     <= a_d;
			start_q <= start_d;
			size_q  <= size_d;
			done_q  <= done_d;
			ok_q    <= ok_d;
			page_q  <= page_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q        <= p_d;
		d_q        <= d_d;
		td_q       <= td_d;
		bf_q       <= bf_d;
		sib_q      <= sib_d;
		prev_odd_q <= prev_odd_d;
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign ok         = ok_q;
	assign page_index = page_q;

endmodule
`default_nettype wire

### src/bpa_checker.sv
`default_nettype none
module bpa_checker
	import bpa_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic              ok,
	input wire logic [PAGE_W-1:0] page_index,
	input wire logic              pool_pages_we
);

	// a result never shows while an item is still in work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// failed items report page 0
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (page_index == '0))
		else $error("nonzero page on failure");

	// nothing happens without an item or a pool write
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start && !pool_pages_we) |=> (!busy && !done))
		else $error("spurious activity");

	// every result traces back to an accepted item
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without item");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.ok            (ok),
	.page_index    (page_index),
	.pool_pages_we (pool_pages_we)
);
`default_nettype wire
